FILE: rtl/tss_pkg.sv
// shared types, field layout and constants of the tone and scale sequencer
package tss_pkg;

    // field widths of the stream items
    localparam int FREQ_W  = 20;
    localparam int DUTY_W  = 20;
    localparam int HUND_W  = 14;
    localparam int DUR_W   = 32;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int MODE_W  = 2;
    localparam int ACT_W   = 3;
    localparam int RES_W   = 5;

    // input tdata layout, lowest bit first
    localparam int IN_FREQ_LSB  = 0;
    localparam int IN_HUND_LSB  = IN_FREQ_LSB + FREQ_W;
    localparam int IN_DUR_LSB   = IN_HUND_LSB + HUND_W;
    localparam int IN_COUNT_LSB = IN_DUR_LSB + DUR_W;
    localparam int IN_UP_LSB    = IN_COUNT_LSB + COUNT_W;
    localparam int IN_SLOT_LSB  = IN_UP_LSB + 1;
    localparam int IN_USED_W    = IN_SLOT_LSB + SLOT_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_FREQ_LSB = 0;
    localparam int OUT_DUTY_LSB = OUT_FREQ_LSB + FREQ_W;
    localparam int OUT_MODE_LSB = OUT_DUTY_LSB + DUTY_W;
    localparam int OUT_BUSY_LSB = OUT_MODE_LSB + MODE_W;
    localparam int OUT_REJ_LSB  = OUT_BUSY_LSB + 1;
    localparam int OUT_FIN_LSB  = OUT_REJ_LSB + 1;
    localparam int OUT_USED_W   = OUT_FIN_LSB + 1;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // resolution limits
    localparam logic [RES_W-1:0] RES_MIN   = 5'd1;
    localparam logic [RES_W-1:0] RES_MAX   = 5'd20;
    localparam logic [RES_W-1:0] RES_RESET = 5'd10;

    // duty arithmetic: x / 10000 = (x >> 4) / 625, the latter by reciprocal
    localparam logic [HUND_W-1:0] HUND_FULL   = 14'd10000;
    localparam int                SCALED_W    = HUND_W + DUTY_W + 1;
    localparam int                QUOT_IN_W   = 30;
    localparam int                RECIP_W     = 31;
    localparam int                RECIP_SHIFT = 40;
    localparam logic [RECIP_W-1:0] RECIP_625  = 31'd1759218605;

    // defaults of the top level parameters
    localparam int NOTE_SLOTS_DEFAULT = 16;
    localparam int FREQ_BITS_DEFAULT  = 20;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_TONE_DUTY  = 3'd1,
        ACT_TONE_HALF  = 3'd2,
        ACT_SCALE      = 3'd3,
        ACT_STOP       = 3'd4,
        ACT_LOAD       = 3'd5
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_DUTY = 2'd1,
        MODE_HALF = 2'd2
    } mode_t;

endpackage

FILE: rtl/tss_duty.sv
// pwm compare values from the duty resolution: scaled duty and half scale
module tss_duty
(
    input  logic [tss_pkg::RES_W-1:0]  res,
    input  logic [tss_pkg::HUND_W-1:0] hund,
    output logic [tss_pkg::DUTY_W-1:0] duty_scaled,
    output logic [tss_pkg::DUTY_W-1:0] duty_half
);

    localparam int PROD_W = tss_pkg::QUOT_IN_W + tss_pkg::RECIP_W;

    logic [tss_pkg::RES_W-1:0]     res_eff;
    logic [tss_pkg::HUND_W-1:0]    hund_eff;
    logic [tss_pkg::SCALED_W-1:0]  scaled;
    logic [tss_pkg::QUOT_IN_W-1:0] quot_in;
    logic [PROD_W-1:0]             prod;

    // resolution 0 acts as 1, above the top acts as the top
    always_comb
    begin
        if (res < tss_pkg::RES_MIN)
            res_eff = tss_pkg::RES_MIN;
        else if (res > tss_pkg::RES_MAX)
            res_eff = tss_pkg::RES_MAX;
        else
            res_eff = res;
    end

    assign hund_eff = (hund > tss_pkg::HUND_FULL) ? tss_pkg::HUND_FULL : hund;

    // (2^r - 1) * h as a shift and a subtract
    assign scaled = (tss_pkg::SCALED_W'(hund_eff) << res_eff)
                  - tss_pkg::SCALED_W'(hund_eff);

    // divide by 16 first, then by 625 through the reciprocal (exact below 2^30)
    assign quot_in = scaled[tss_pkg::QUOT_IN_W+3:4];
    assign prod    = PROD_W'(quot_in) * PROD_W'(tss_pkg::RECIP_625);

    assign duty_scaled = prod[tss_pkg::RECIP_SHIFT +: tss_pkg::DUTY_W];
    assign duty_half   = tss_pkg::DUTY_W'(1) << (res_eff - tss_pkg::RES_MIN);

endmodule

FILE: rtl/tone_and_scale_sequencer.sv
// top level of the buzzer tone and scale sequencer
//
// usage:
//   each item on the slave stream is one command, selected by s_tuser: a
//   one-millisecond tick, a tone with a given duty, a tone at half scale,
//   a scale start over the note table, a stop, or a note table load.
//   every item gives exactly one result item on the master stream with the
//   sounding frequency, the pwm compare value, the drive mode and the
//   busy, rejected and finished flags.
//   the cfg channel writes the duty resolution in bits; write it only
//   while no item is in flight. cfg_ready is always high.
// registers and throughput:
//   an item lands in an input register, and from there its result moves
//   into the output register that drives m_tvalid. one item per cycle is
//   sustained while m_tready is high; the state update and the duty
//   multiply are combinational, and the note table read is prefetched.
// stalls and reset:
//   while m_tready is low the result holds and one more item is still
//   taken into the input register, then s_tready drops.
//   reset silences the block, empties both registers and sets resolution
//   to 10 bits; the note table keeps whatever it held and needs loading.
module tone_and_scale_sequencer
#(
    parameter int NOTE_SLOTS = tss_pkg::NOTE_SLOTS_DEFAULT,
    parameter int FREQ_BITS  = tss_pkg::FREQ_BITS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // config write: duty resolution
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tss_pkg::RES_W-1:0]        cfg_data,
    // command items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frequency, duty_hundredths, duration_ms, note_count, direction_up, note_slot
    input  logic [tss_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action
    input  logic [tss_pkg::ACT_W-1:0]        s_tuser,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tone_frequency, duty_value, drive_mode, busy_res, rejected, finished
    output logic [tss_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // kept frequency bits, table index and count widths
    localparam int TW   = (FREQ_BITS < tss_pkg::FREQ_W) ? FREQ_BITS : tss_pkg::FREQ_W;
    localparam int PW   = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int CW   = $clog2(NOTE_SLOTS + 1);
    localparam int NW   = 9;
    localparam logic [NW-1:0] SLOTS_N = NW'(NOTE_SLOTS);
    localparam logic [tss_pkg::DUR_W-1:0] ELAPSED_MAX = '1;

    // input register
    logic                          in_valid_reg;
    tss_pkg::action_t              in_action_reg;
    logic [tss_pkg::FREQ_W-1:0]    in_freq_reg;
    logic [tss_pkg::HUND_W-1:0]    in_hund_reg;
    logic [tss_pkg::DUR_W-1:0]     in_dur_reg;
    logic [tss_pkg::COUNT_W-1:0]   in_count_reg;
    logic                          in_up_reg;
    logic [tss_pkg::SLOT_W-1:0]    in_slot_reg;

    // output register
    logic                          out_valid_reg;
    logic [tss_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [tss_pkg::OUT_TDATA_W-1:0] out_data_next;

    // sequencer state
    logic [tss_pkg::RES_W-1:0]     res_reg;
    logic                          tone_reg,   tone_next;
    logic                          scale_reg,  scale_next;
    logic [TW-1:0]                 freq_reg,   freq_next;
    logic [tss_pkg::DUTY_W-1:0]    duty_reg,   duty_next;
    tss_pkg::mode_t                mode_reg,   mode_next;
    logic [tss_pkg::DUR_W-1:0]     elapsed_reg, elapsed_next;
    logic [tss_pkg::DUR_W-1:0]     period_reg, period_next;
    logic [PW-1:0]                 pos_reg,    pos_next;
    logic [CW-1:0]                 notes_reg,  notes_next;
    logic                          asc_reg,    asc_next;

    // note table and its prefetched read
    logic [TW-1:0]                 note_mem [NOTE_SLOTS];
    logic [TW-1:0]                 rd_data_reg;
    logic [PW-1:0]                 rd_addr;
    logic [PW-1:0]                 wr_addr;
    logic                          wr_en;
    logic                          rejected;
    logic                          finished;
    logic                          busy_now;

    logic                          advance;
    logic                          take_in;
    tss_pkg::action_t              s_action;
    logic [NW-1:0]                 s_count_n;
    logic [NW-1:0]                 in_count_n;
    logic [NW-1:0]                 in_slot_n;
    logic [tss_pkg::DUR_W-1:0]     elapsed_inc;
    logic                          period_done;
    logic [tss_pkg::DUTY_W-1:0]    duty_scaled;
    logic [tss_pkg::DUTY_W-1:0]    duty_half;

    tss_duty u_duty
    (
        .res         (res_reg),
        .hund        (in_hund_reg),
        .duty_scaled (duty_scaled),
        .duty_half   (duty_half)
    );

    // handshakes: input register refills as it drains
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign take_in   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign s_action  = tss_pkg::action_t'(s_tuser);

    // note counts clamped to the table depth
    always_comb
    begin
        s_count_n  = NW'(s_tdata[tss_pkg::IN_COUNT_LSB +: tss_pkg::COUNT_W]);
        if (s_count_n > SLOTS_N)
            s_count_n = SLOTS_N;
        in_count_n = NW'(in_count_reg);
        if (in_count_n > SLOTS_N)
            in_count_n = SLOTS_N;
    end

    assign in_slot_n   = NW'(in_slot_reg);
    assign busy_now    = tone_reg || scale_reg;
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign period_done = elapsed_inc >= period_reg;

    // next state and the result of the item in the input register
    always_comb
    begin
        tone_next    = tone_reg;
        scale_next   = scale_reg;
        freq_next    = freq_reg;
        duty_next    = duty_reg;
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        period_next  = period_reg;
        pos_next     = pos_reg;
        notes_next   = notes_reg;
        asc_next     = asc_reg;
        rejected     = 1'b0;
        finished     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = PW'(in_slot_n);

        if (advance)
        begin
            unique case (in_action_reg)
                tss_pkg::ACT_TICK:
                begin
                    if (busy_now)
                    begin
                        elapsed_next = elapsed_inc;
                        if (period_done)
                        begin
                            // last note or end of tone: silence
                            if (tone_reg
                                || (asc_reg && (NW'(pos_reg) + 1'b1 >= NW'(notes_reg)))
                                || (!asc_reg && (pos_reg == '0)))
                            begin
                                tone_next  = 1'b0;
                                scale_next = 1'b0;
                                freq_next  = '0;
                                duty_next  = '0;
                                mode_next  = tss_pkg::MODE_OFF;
                                finished   = 1'b1;
                            end
                            else
                            begin
                                // step to the neighbor note, read ahead of time
                                pos_next     = asc_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                                freq_next    = rd_data_reg;
                                duty_next    = duty_half;
                                mode_next    = tss_pkg::MODE_HALF;
                                elapsed_next = '0;
                            end
                        end
                    end
                end
                tss_pkg::ACT_TONE_DUTY, tss_pkg::ACT_TONE_HALF:
                begin
                    if (busy_now)
                        rejected = 1'b1;
                    else
                    begin
                        if (in_action_reg == tss_pkg::ACT_TONE_DUTY)
                        begin
                            duty_next = duty_scaled;
                            mode_next = tss_pkg::MODE_DUTY;
                        end
                        else
                        begin
                            duty_next = duty_half;
                            mode_next = tss_pkg::MODE_HALF;
                        end
                        freq_next    = in_freq_reg[TW-1:0];
                        elapsed_next = '0;
                        period_next  = in_dur_reg;
                        tone_next    = 1'b1;
                    end
                end
                tss_pkg::ACT_SCALE:
                begin
                    if (busy_now || (in_count_n == '0))
                        rejected = 1'b1;
                    else
                    begin
                        notes_next   = CW'(in_count_n);
                        period_next  = in_dur_reg;
                        asc_next     = in_up_reg;
                        pos_next     = in_up_reg ? '0 : PW'(in_count_n - 1'b1);
                        scale_next   = 1'b1;
                        freq_next    = rd_data_reg;
                        duty_next    = duty_half;
                        mode_next    = tss_pkg::MODE_HALF;
                        elapsed_next = '0;
                    end
                end
                tss_pkg::ACT_STOP:
                begin
                    tone_next  = 1'b0;
                    scale_next = 1'b0;
                    freq_next  = '0;
                    duty_next  = '0;
                    mode_next  = tss_pkg::MODE_OFF;
                end
                tss_pkg::ACT_LOAD:
                begin
                    wr_en = in_slot_n < SLOTS_N;
                end
                default:
                begin
                end
            endcase
        end

        out_data_next = '0;
        out_data_next[tss_pkg::OUT_FREQ_LSB +: tss_pkg::FREQ_W] = tss_pkg::FREQ_W'(freq_next);
        out_data_next[tss_pkg::OUT_DUTY_LSB +: tss_pkg::DUTY_W] = duty_next;
        out_data_next[tss_pkg::OUT_MODE_LSB +: tss_pkg::MODE_W] = mode_next;
        out_data_next[tss_pkg::OUT_BUSY_LSB] = tone_next || scale_next;
        out_data_next[tss_pkg::OUT_REJ_LSB]  = rejected;
        out_data_next[tss_pkg::OUT_FIN_LSB]  = finished;
    end

    // read address for the item being taken, from the state it will see
    always_comb
    begin
        if (s_action == tss_pkg::ACT_SCALE)
        begin
            if (s_tdata[tss_pkg::IN_UP_LSB])
                rd_addr = '0;
            else
                rd_addr = PW'(s_count_n - 1'b1);
        end
        else if (asc_next)
            rd_addr = pos_next + 1'b1;
        else
            rd_addr = pos_next - 1'b1;
    end

    // note table: write on a load, registered read with write bypass
    always_ff @(posedge clk)
    begin
        if (wr_en)
            note_mem[wr_addr] <= in_freq_reg[TW-1:0];
        if (take_in)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= in_freq_reg[TW-1:0];
            else
                rd_data_reg <= note_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_action_reg <= s_action;
            in_freq_reg   <= s_tdata[tss_pkg::IN_FREQ_LSB  +: tss_pkg::FREQ_W];
            in_hund_reg   <= s_tdata[tss_pkg::IN_HUND_LSB  +: tss_pkg::HUND_W];
            in_dur_reg    <= s_tdata[tss_pkg::IN_DUR_LSB   +: tss_pkg::DUR_W];
            in_count_reg  <= s_tdata[tss_pkg::IN_COUNT_LSB +: tss_pkg::COUNT_W];
            in_up_reg     <= s_tdata[tss_pkg::IN_UP_LSB];
            in_slot_reg   <= s_tdata[tss_pkg::IN_SLOT_LSB  +: tss_pkg::SLOT_W];
        end
        if (advance)
            out_data_reg <= out_data_next;
    end

    // control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= tss_pkg::RES_RESET;
            tone_reg      <= 1'b0;
            scale_reg     <= 1'b0;
            freq_reg      <= '0;
            duty_reg      <= '0;
            mode_reg      <= tss_pkg::MODE_OFF;
            elapsed_reg   <= '0;
            period_reg    <= '0;
            pos_reg       <= '0;
            notes_reg     <= '0;
            asc_reg       <= 1'b1;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                res_reg <= cfg_data;

            tone_reg    <= tone_next;
            scale_reg   <= scale_next;
            freq_reg    <= freq_next;
            duty_reg    <= duty_next;
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            period_reg  <= period_next;
            pos_reg     <= pos_next;
            notes_reg   <= notes_next;
            asc_reg     <= asc_next;
        end
    end

endmodule
